// ===== design/bkv_pkg.sv =====
// Shared types, codes and key tables for the binary key-value shortcut parser.
`default_nettype none

package bkv_pkg;

	// Input transaction: one file byte and its end-of-file mark
	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} item_t;

	// Output transaction: one parser event
	typedef struct packed {
		logic [2:0]  event_kind;
		logic [1:0]  field_tag;
		logic [31:0] value;
		logic [2:0]  err_code;
		logic        last_of_run;
	} result_t;

	// Up to two events caused by one byte, in order
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} parse_run_t;

	localparam int DEF_MAX_DEPTH = 8;

	// Event kinds
	localparam logic [2:0] EV_BYTE   = 3'd0;
	localparam logic [2:0] EV_END    = 3'd1;
	localparam logic [2:0] EV_ID     = 3'd2;
	localparam logic [2:0] EV_DONE   = 3'd3;
	localparam logic [2:0] EV_FINISH = 3'd4;
	localparam logic [2:0] EV_ERROR  = 3'd5;

	// Error codes
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_HEADER    = 3'd1;
	localparam logic [2:0] ERR_ENTRY     = 3'd2;
	localparam logic [2:0] ERR_TYPE      = 3'd3;
	localparam logic [2:0] ERR_DEPTH     = 3'd4;
	localparam logic [2:0] ERR_TRUNCATED = 3'd5;

	// Captured string fields
	localparam logic [1:0] TAG_NAME = 2'd0;
	localparam logic [1:0] TAG_EXE  = 2'd1;
	localparam logic [1:0] TAG_ICON = 2'd2;

	// Element type bytes
	localparam logic [7:0] TYPE_MAP    = 8'h00;
	localparam logic [7:0] TYPE_STRING = 8'h01;
	localparam logic [7:0] TYPE_INT32  = 8'h02;
	localparam logic [7:0] TYPE_FLOAT  = 8'h03;
	localparam logic [7:0] TYPE_PTR    = 8'h04;
	localparam logic [7:0] TYPE_COLOR  = 8'h06;
	localparam logic [7:0] TYPE_UINT64 = 8'h07;
	localparam logic [7:0] TYPE_END    = 8'h08;
	localparam logic [7:0] TYPE_INT64  = 8'h0A;

	// Known keys, one match flag each
	localparam int NKEYS         = 5;
	localparam int KEY_APPNAME   = 0;
	localparam int KEY_EXE       = 1;
	localparam int KEY_ICON      = 2;
	localparam int KEY_APPID     = 3;
	localparam int KEY_SHORTCUTS = 4;

	typedef logic [0:15][7:0] key_text_t;

	localparam key_text_t KEY_TEXT [NKEYS] = '{
		{"appname", 72'h0},
		{"exe", 104'h0},
		{"icon", 96'h0},
		{"appid", 88'h0},
		{"shortcuts", 56'h0}
	};

	localparam logic [3:0] KEY_LEN [NKEYS] = '{4'd7, 4'd3, 4'd4, 4'd5, 4'd9};

	// Build one event with last_of_run clear
	function automatic result_t make_result(input logic [2:0] kind, input logic [1:0] tag,
			input logic [31:0] val, input logic [2:0] err);
		result_t r;
		r.event_kind  = kind;
		r.field_tag   = tag;
		r.value       = val;
		r.err_code    = err;
		r.last_of_run = 1'b0;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== design/bkv_parse.sv =====
// Byte-wise parser state machine: next state and up to two events per byte.
`default_nettype none

module bkv_parse
	import bkv_pkg::*;
#(
	parameter int MAX_DEPTH = DEF_MAX_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       fire,
	input  wire item_t      item,
	output parse_run_t      run
);

	localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);

	typedef enum logic [3:0] {
		PH_HDR_TYPE,
		PH_HDR_KEY,
		PH_TOP_TYPE,
		PH_TOP_KEY,
		PH_MAP_TYPE,
		PH_MAP_KEY,
		PH_STR_CAP,
		PH_STR_SKIP,
		PH_INT,
		PH_SKIP,
		PH_IDLE
	} phase_t;

	phase_t               phase_q, phase_d;
	logic [DEPTH_W-1:0]   depth_q, depth_d, depth_dn;
	logic [7:0]           ptype_q, ptype_d;
	logic [NKEYS-1:0]     match_q, match_d;
	logic [3:0]           kpos_q, kpos_d, kpos_inc;
	logic [2:0]           bcnt_q, bcnt_d;
	logic [31:0]          acc_q, acc_d, acc_or;
	logic [1:0]           tag_q, tag_d;

	logic [7:0]           b;
	logic [7:0]           lc;
	logic [NKEYS-1:0]     step_ok, end_ok, key_done;
	logic                 ev_a_vld, ev_b_vld;
	result_t              ev_a, ev_b;

	assign b        = item.data_byte;
	assign depth_dn = (depth_q != '0) ? depth_q - DEPTH_W'(1) : depth_q;
	assign kpos_inc = (kpos_q == 4'hF) ? kpos_q : kpos_q + 4'd1;
	assign key_done = match_q & end_ok;

	// Fold A-Z and compare the byte against each key at the current position
	always_comb begin
		lc = ((b >= 8'h41) && (b <= 8'h5A)) ? b + 8'h20 : b;
		for (int k = 0; k < NKEYS; k++) begin
			step_ok[k] = (kpos_q < KEY_LEN[k]) && (KEY_TEXT[k][kpos_q] == lc);
			end_ok[k]  = (kpos_q == KEY_LEN[k]);
		end
	end

	// Place an int32 byte little-endian
	always_comb begin
		unique case (bcnt_q[1:0])
			2'd3: acc_or = {24'h0, b};
			2'd2: acc_or = {16'h0, b, 8'h0};
			2'd1: acc_or = {8'h0, b, 16'h0};
			2'd0: acc_or = {b, 24'h0};
		endcase
	end

	// Advance the parser by one byte
	always_comb begin
		phase_d  = phase_q;
		depth_d  = depth_q;
		ptype_d  = ptype_q;
		match_d  = match_q;
		kpos_d   = kpos_q;
		bcnt_d   = bcnt_q;
		acc_d    = acc_q;
		tag_d    = tag_q;
		ev_a_vld = 1'b0;
		ev_a     = make_result(EV_BYTE, TAG_NAME, 32'h0, ERR_NONE);
		ev_b_vld = 1'b0;
		ev_b     = make_result(EV_BYTE, TAG_NAME, 32'h0, ERR_NONE);

		unique case (phase_q)
			PH_HDR_TYPE: begin
				if (b == TYPE_MAP) begin
					phase_d = PH_HDR_KEY;
					match_d = '1;
					kpos_d  = 4'd0;
				end else begin
					ev_a_vld = 1'b1;
					ev_a     = make_result(EV_ERROR, TAG_NAME, 32'h0, ERR_HEADER);
					phase_d  = PH_IDLE;
				end
			end
			PH_HDR_KEY: begin
				if (b != 8'h00) begin
					match_d = match_q & step_ok;
					kpos_d  = kpos_inc;
				end else begin
					match_d = key_done;
					if (key_done[KEY_SHORTCUTS]) begin
						phase_d = PH_TOP_TYPE;
					end else begin
						ev_a_vld = 1'b1;
						ev_a     = make_result(EV_ERROR, TAG_NAME, 32'h0, ERR_HEADER);
						phase_d  = PH_IDLE;
					end
				end
			end
			PH_TOP_TYPE: begin
				if (b == TYPE_END) begin
					ev_a_vld = 1'b1;
					ev_a     = make_result(EV_FINISH, TAG_NAME, 32'h0, ERR_NONE);
					phase_d  = PH_IDLE;
				end else if (b == TYPE_MAP) begin
					phase_d = PH_TOP_KEY;
				end else begin
					ev_a_vld = 1'b1;
					ev_a     = make_result(EV_ERROR, TAG_NAME, 32'h0, ERR_ENTRY);
					phase_d  = PH_IDLE;
				end
			end
			PH_TOP_KEY: begin
				if (b == 8'h00) begin
					depth_d = DEPTH_W'(1);
					phase_d = PH_MAP_TYPE;
				end
			end
			PH_MAP_TYPE: begin
				if (b == TYPE_END) begin
					depth_d = depth_dn;
					if (depth_dn == '0) begin
						ev_a_vld = 1'b1;
						ev_a     = make_result(EV_DONE, TAG_NAME, 32'h0, ERR_NONE);
						phase_d  = PH_TOP_TYPE;
					end
				end else begin
					ptype_d = b;
					match_d = '1;
					kpos_d  = 4'd0;
					phase_d = PH_MAP_KEY;
				end
			end
			PH_MAP_KEY: begin
				if (b != 8'h00) begin
					match_d = match_q & step_ok;
					kpos_d  = kpos_inc;
				end else begin
					match_d = key_done;
					// Dispatch on the element type once the key is complete
					if (ptype_q == TYPE_MAP) begin
						if (depth_q >= DEPTH_W'(MAX_DEPTH)) begin
							ev_a_vld = 1'b1;
							ev_a     = make_result(EV_ERROR, TAG_NAME, 32'h0, ERR_DEPTH);
							phase_d  = PH_IDLE;
						end else begin
							depth_d = depth_q + DEPTH_W'(1);
							phase_d = PH_MAP_TYPE;
						end
					end else if (ptype_q == TYPE_STRING) begin
						phase_d = PH_STR_SKIP;
						if (depth_q == DEPTH_W'(1)) begin
							if (key_done[KEY_APPNAME]) begin
								tag_d   = TAG_NAME;
								phase_d = PH_STR_CAP;
							end else if (key_done[KEY_EXE]) begin
								tag_d   = TAG_EXE;
								phase_d = PH_STR_CAP;
							end else if (key_done[KEY_ICON]) begin
								tag_d   = TAG_ICON;
								phase_d = PH_STR_CAP;
							end
						end
					end else if (ptype_q == TYPE_INT32) begin
						acc_d   = 32'h0;
						bcnt_d  = 3'd3;
						phase_d = PH_INT;
					end else if ((ptype_q == TYPE_FLOAT) || (ptype_q == TYPE_PTR) ||
							(ptype_q == TYPE_COLOR)) begin
						bcnt_d  = 3'd3;
						phase_d = PH_SKIP;
					end else if ((ptype_q == TYPE_UINT64) || (ptype_q == TYPE_INT64)) begin
						bcnt_d  = 3'd7;
						phase_d = PH_SKIP;
					end else begin
						ev_a_vld = 1'b1;
						ev_a     = make_result(EV_ERROR, TAG_NAME, 32'h0, ERR_TYPE);
						phase_d  = PH_IDLE;
					end
				end
			end
			PH_STR_CAP: begin
				ev_a_vld = 1'b1;
				if (b == 8'h00) begin
					ev_a    = make_result(EV_END, tag_q, 32'h0, ERR_NONE);
					phase_d = PH_MAP_TYPE;
				end else begin
					ev_a = make_result(EV_BYTE, tag_q, {24'h0, b}, ERR_NONE);
				end
			end
			PH_STR_SKIP: begin
				if (b == 8'h00) begin
					phase_d = PH_MAP_TYPE;
				end
			end
			PH_INT: begin
				acc_d = acc_q | acc_or;
				if (bcnt_q == 3'd0) begin
					if ((depth_q == DEPTH_W'(1)) && match_q[KEY_APPID]) begin
						ev_a_vld = 1'b1;
						ev_a     = make_result(EV_ID, TAG_NAME, acc_q | acc_or, ERR_NONE);
					end
					phase_d = PH_MAP_TYPE;
				end else begin
					bcnt_d = bcnt_q - 3'd1;
				end
			end
			PH_SKIP: begin
				if (bcnt_q == 3'd0) begin
					phase_d = PH_MAP_TYPE;
				end else begin
					bcnt_d = bcnt_q - 3'd1;
				end
			end
			PH_IDLE: begin
				phase_d = PH_IDLE;
			end
			default: begin
				phase_d = phase_q;
			end
		endcase

		// Close the file on the final byte and rearm
		if (item.final_byte) begin
			if (phase_d == PH_TOP_TYPE) begin
				ev_b_vld = 1'b1;
				ev_b     = make_result(EV_FINISH, TAG_NAME, 32'h0, ERR_NONE);
			end else if ((phase_d == PH_HDR_TYPE) || (phase_d == PH_HDR_KEY)) begin
				ev_b_vld = 1'b1;
				ev_b     = make_result(EV_ERROR, TAG_NAME, 32'h0, ERR_HEADER);
			end else if (phase_d != PH_IDLE) begin
				ev_b_vld = 1'b1;
				ev_b     = make_result(EV_ERROR, TAG_NAME, 32'h0, ERR_TRUNCATED);
			end
			phase_d = PH_HDR_TYPE;
			depth_d = '0;
			ptype_d = 8'h00;
			match_d = '1;
			kpos_d  = 4'd0;
			bcnt_d  = 3'd0;
			acc_d   = 32'h0;
			tag_d   = TAG_NAME;
		end
	end

	// Pack the events of this byte in order and mark the last one
	always_comb begin
		run.count  = 2'd0;
		run.first  = ev_a;
		run.second = ev_b;
		if (ev_a_vld && ev_b_vld) begin
			run.count              = 2'd2;
			run.second.last_of_run = 1'b1;
		end else if (ev_a_vld) begin
			run.count             = 2'd1;
			run.first.last_of_run = 1'b1;
		end else if (ev_b_vld) begin
			run.count             = 2'd1;
			run.first             = ev_b;
			run.first.last_of_run = 1'b1;
		end
	end

	// Hold parser state between transactions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR_TYPE;
			depth_q <= '0;
			ptype_q <= 8'h00;
			match_q <= '1;
			kpos_q  <= 4'd0;
			bcnt_q  <= 3'd0;
			acc_q   <= 32'h0;
			tag_q   <= TAG_NAME;
		end else if (fire) begin
			phase_q <= phase_d;
			depth_q <= depth_d;
			ptype_q <= ptype_d;
			match_q <= match_d;
			kpos_q  <= kpos_d;
			bcnt_q  <= bcnt_d;
			acc_q   <= acc_d;
			tag_q   <= tag_d;
		end
	end

	// Nesting never passes the limit
	a_depth_limit: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_W'(MAX_DEPTH))
		else $error("nesting depth above limit");

	// A final byte always rearms the parser
	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.final_byte |=> (phase_q == PH_HDR_TYPE) && (depth_q == '0))
		else $error("parser not rearmed after final byte");

	// Capturing a string only happens inside an entry
	a_capture_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_STR_CAP) |-> (depth_q == DEPTH_W'(1)))
		else $error("string capture outside entry depth");

endmodule

`default_nettype wire

// ===== design/bkv_outq.sv =====
// Small result queue that takes up to two events a cycle and gives one.
`default_nettype none

module bkv_outq
	import bkv_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire parse_run_t run,
	output logic            room,
	output logic            result_valid,
	input  wire logic       result_ready,
	output result_t         result
);

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	result_t            mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q, wr_ptr_nx;
	logic [CNT_W-1:0]   cnt_q;
	logic [1:0]         n_push;
	logic               pop;

	assign n_push       = push ? run.count : 2'd0;
	assign pop          = result_valid && result_ready;
	assign wr_ptr_nx    = wr_ptr_q + PTR_W'(1);
	assign room         = (cnt_q <= CNT_W'(DEPTH - 2));
	assign result_valid = (cnt_q != '0);
	assign result       = mem_q[rd_ptr_q];

	// Write the events of one transaction
	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			mem_q[wr_ptr_q] <= run.first;
		end
		if (n_push == 2'd2) begin
			mem_q[wr_ptr_nx] <= run.second;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + CNT_W'(n_push) - CNT_W'(pop);
		end
	end

	// Fill level stays within the queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("result queue overflow");

	// Pushes arrive only while there is room for a full run
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(n_push != 2'd0) |-> room)
		else $error("push without room");

	// Read pointer trails write pointer by the fill level
	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		PTR_W'(wr_ptr_q - rd_ptr_q) == PTR_W'(cnt_q))
		else $error("queue pointers out of step with fill level");

endmodule

`default_nettype wire

// ===== design/binary_keyvalue_shortcut_parser.sv =====
// Top level: byte parser feeding a result queue.
// The events of an accepted byte are registered into the result queue and leave it in order behind older results.
// Throughput: one byte per cycle while the queue has room; a byte that causes two results (only with the final
// byte) queues both, and the queue drains one result per cycle while result_ready is high.
// item_ready stays high while the four-entry result queue has room for two results.
// Reset (arst_n low) returns the parser to expecting a header and empties the queue.
`default_nettype none

module binary_keyvalue_shortcut_parser
	import bkv_pkg::*;
#(
	parameter int MAX_DEPTH = DEF_MAX_DEPTH
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  item_valid,
	output logic       item_ready,
	input  wire item_t item,
	output logic       result_valid,
	input  wire logic  result_ready,
	output result_t    result
);

	logic       fire;
	parse_run_t run;

	assign fire = item_valid && item_ready;

	// Parse one byte per transaction
	bkv_parse #(
		.MAX_DEPTH(MAX_DEPTH)
	) u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item),
		.run    (run)
	);

	// Queue events toward the consumer
	bkv_outq u_outq (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (fire),
		.run          (run),
		.room         (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// Two events from one byte only on the final byte
	a_two_on_final: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (run.count == 2'd2) |-> item.final_byte)
		else $error("two results from a non-final byte");

	// Error code is set exactly on error events
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((result.event_kind == EV_ERROR) == (result.err_code != ERR_NONE)))
		else $error("error code does not match event kind");

	// Value is zero unless a string byte or an id
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.event_kind != EV_BYTE) && (result.event_kind != EV_ID)
		|-> (result.value == 32'h0))
		else $error("value set on an event without payload");

endmodule

`default_nettype wire

// ===== dv/bkv_event_checker.sv =====
// Event checker for the shortcut parser: predicts events per byte and compares them in order.
module bkv_event_checker
	import bkv_pkg::*;
#(
	parameter int MAX_DEPTH = DEF_MAX_DEPTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	input  logic    item_ready,
	input  item_t   item,
	input  logic    result_valid,
	input  logic    result_ready,
	input  result_t result,
	output int      mismatches,
	output int      outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [3:0] {
		ST_HDR_TYPE,
		ST_HDR_KEY,
		ST_TOP_TYPE,
		ST_TOP_KEY,
		ST_MAP_TYPE,
		ST_MAP_KEY,
		ST_STR_CAP,
		ST_STR_SKIP,
		ST_INT,
		ST_SKIP,
		ST_IDLE
	} parse_state_t;

	localparam logic [1:0] NO_TAG   = 2'd0;
	localparam logic [4:0] ALL_KEYS = 5'h1F;

	// Predicted parser state
	parse_state_t state;
	logic [3:0]   depth;
	logic [7:0]   elem_type;
	logic [4:0]   key_hits;
	logic [3:0]   key_pos;
	logic [2:0]   bytes_left;
	logic [31:0]  id_acc;
	logic [1:0]   cap_tag;

	result_t byte_events[$];
	result_t expected_events[$];
	result_t want;
	int      miss_count = 0;

	task automatic reset_parser();
		state      = ST_HDR_TYPE;
		depth      = '0;
		elem_type  = '0;
		key_hits   = ALL_KEYS;
		key_pos    = '0;
		bytes_left = '0;
		id_acc     = '0;
		cap_tag    = NO_TAG;
	endtask

	task automatic restart_key();
		key_hits = ALL_KEYS;
		key_pos  = '0;
	endtask

	task automatic post_event(input logic [2:0] kind, input logic [1:0] tag,
			input logic [31:0] val, input logic [2:0] err);
		result_t r;
		r.event_kind  = kind;
		r.field_tag   = tag;
		r.value       = val;
		r.err_code    = err;
		r.last_of_run = 1'b0;
		byte_events = {byte_events, r};
	endtask

	task automatic abort_file(input logic [2:0] code);
		post_event(EV_ERROR, NO_TAG, 32'd0, code);
		state = ST_IDLE;
	endtask

	// Drop every known key that disagrees with this key byte (A-Z fold to lower case)
	task automatic match_key_byte(input logic [7:0] b);
		logic [7:0] c;
		int k;
		c = (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
		for (k = 0; k < NKEYS; k++) begin
			if (!(key_pos < KEY_LEN[k] && KEY_TEXT[k][key_pos] == c))
				key_hits[k] = 1'b0;
		end
		if (key_pos != 4'd15)
			key_pos++;
	endtask

	// Keep only keys whose length matches at the terminating NUL
	task automatic close_key();
		int k;
		for (k = 0; k < NKEYS; k++) begin
			if (key_pos != KEY_LEN[k])
				key_hits[k] = 1'b0;
		end
	endtask

	// Choose how to read the value of the element whose key just ended
	task automatic open_value();
		case (elem_type)
			TYPE_MAP: begin
				if (int'(depth) + 1 > MAX_DEPTH) begin
					abort_file(ERR_DEPTH);
				end else begin
					depth++;
					state = ST_MAP_TYPE;
				end
			end
			TYPE_STRING: begin
				state = ST_STR_SKIP;
				if (depth == 4'd1) begin
					if (key_hits[KEY_APPNAME]) begin
						cap_tag = TAG_NAME;
						state   = ST_STR_CAP;
					end else if (key_hits[KEY_EXE]) begin
						cap_tag = TAG_EXE;
						state   = ST_STR_CAP;
					end else if (key_hits[KEY_ICON]) begin
						cap_tag = TAG_ICON;
						state   = ST_STR_CAP;
					end
				end
			end
			TYPE_INT32: begin
				id_acc     = '0;
				bytes_left = 3'd3;
				state      = ST_INT;
			end
			TYPE_FLOAT, TYPE_PTR, TYPE_COLOR: begin
				bytes_left = 3'd3;
				state      = ST_SKIP;
			end
			TYPE_UINT64, TYPE_INT64: begin
				bytes_left = 3'd7;
				state      = ST_SKIP;
			end
			default: begin
				abort_file(ERR_TYPE);
			end
		endcase
	endtask

	// Advance the predicted parser by one byte and queue the events it causes
	task automatic step_parser(input logic [7:0] b, input logic fin);
		logic [1:0] lane;
		int last;
		byte_events.delete();
		case (state)
			ST_HDR_TYPE: begin
				if (b == TYPE_MAP) begin
					state = ST_HDR_KEY;
					restart_key();
				end else begin
					abort_file(ERR_HEADER);
				end
			end
			ST_HDR_KEY: begin
				if (b != 8'h00) begin
					match_key_byte(b);
				end else begin
					close_key();
					if (key_hits[KEY_SHORTCUTS])
						state = ST_TOP_TYPE;
					else
						abort_file(ERR_HEADER);
				end
			end
			ST_TOP_TYPE: begin
				if (b == TYPE_END) begin
					post_event(EV_FINISH, NO_TAG, 32'd0, ERR_NONE);
					state = ST_IDLE;
				end else if (b == TYPE_MAP) begin
					state = ST_TOP_KEY;
				end else begin
					abort_file(ERR_ENTRY);
				end
			end
			ST_TOP_KEY: begin
				if (b == 8'h00) begin
					depth = 4'd1;
					state = ST_MAP_TYPE;
				end
			end
			ST_MAP_TYPE: begin
				if (b == TYPE_END) begin
					if (depth != 4'd0)
						depth--;
					if (depth == 4'd0) begin
						post_event(EV_DONE, NO_TAG, 32'd0, ERR_NONE);
						state = ST_TOP_TYPE;
					end
				end else begin
					elem_type = b;
					restart_key();
					state = ST_MAP_KEY;
				end
			end
			ST_MAP_KEY: begin
				if (b != 8'h00) begin
					match_key_byte(b);
				end else begin
					close_key();
					open_value();
				end
			end
			ST_STR_CAP: begin
				if (b == 8'h00) begin
					post_event(EV_END, cap_tag, 32'd0, ERR_NONE);
					state = ST_MAP_TYPE;
				end else begin
					post_event(EV_BYTE, cap_tag, {24'd0, b}, ERR_NONE);
				end
			end
			ST_STR_SKIP: begin
				if (b == 8'h00)
					state = ST_MAP_TYPE;
			end
			ST_INT: begin
				// little-endian: first byte lands in the low lane
				lane = 2'd3 - bytes_left[1:0];
				id_acc = id_acc | ({24'd0, b} << (8 * lane));
				if (bytes_left == 3'd0) begin
					if (depth == 4'd1 && key_hits[KEY_APPID])
						post_event(EV_ID, NO_TAG, id_acc, ERR_NONE);
					state = ST_MAP_TYPE;
				end else begin
					bytes_left--;
				end
			end
			ST_SKIP: begin
				if (bytes_left == 3'd0)
					state = ST_MAP_TYPE;
				else
					bytes_left--;
			end
			default: begin
			end
		endcase

		// End of file: close out by where the parser stands, then rearm
		if (fin) begin
			if (state == ST_TOP_TYPE)
				post_event(EV_FINISH, NO_TAG, 32'd0, ERR_NONE);
			else if (state == ST_HDR_TYPE || state == ST_HDR_KEY)
				post_event(EV_ERROR, NO_TAG, 32'd0, ERR_HEADER);
			else if (state != ST_IDLE)
				post_event(EV_ERROR, NO_TAG, 32'd0, ERR_TRUNCATED);
			reset_parser();
		end

		last = byte_events.size() - 1;
		if (last >= 0)
			byte_events[last].last_of_run = 1'b1;
		foreach (byte_events[i])
			expected_events = {expected_events, byte_events[i]};
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_parser();
			expected_events.delete();
			miss_count = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			// Compare the result transaction with the oldest prediction
			if (result_valid && result_ready) begin
				if (expected_events.size() == 0) begin
					miss_count++;
					if (miss_count <= 10)
						$display("unexpected event: kind %0d tag %0d value 0x%08h error %0d last %0b",
							result.event_kind, result.field_tag, result.value,
							result.err_code, result.last_of_run);
				end else begin
					want = expected_events.pop_front();
					if (result.event_kind !== want.event_kind ||
							result.field_tag !== want.field_tag ||
							result.value !== want.value ||
							result.err_code !== want.err_code ||
							result.last_of_run !== want.last_of_run) begin
						miss_count++;
						if (miss_count <= 10)
							$display("event mismatch: expected kind %0d tag %0d value 0x%08h",
								want.event_kind, want.field_tag, want.value,
								" error %0d last %0b, got kind %0d tag %0d value 0x%08h",
								want.err_code, want.last_of_run, result.event_kind,
								result.field_tag, result.value,
								" error %0d last %0b", result.err_code, result.last_of_run);
					end
				end
			end

			// Predict what the byte transaction causes
			if (item_valid && item_ready)
				step_parser(item.data_byte, item.final_byte);

			mismatches <= miss_count;
			outstanding <= expected_events.size();
		end
	end

endmodule

// ===== dv/testbench.sv =====
// Testbench top for the shortcut parser: clock, reset, byte-file stimulus and verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import bkv_pkg::*;

	localparam int ITEM_GOAL = 800;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	item_t   item = '0;
	logic    result_ready = 1'b0;
	logic    item_ready;
	logic    result_valid;
	result_t result;
	int      mismatches;
	int      outstanding;

	item_t file_bytes[$];
	int    burst_left = 0;
	int    items_sent = 0;

	int unsigned ready_pct = 100;
	int          ready_mode_left = 0;

	binary_keyvalue_shortcut_parser dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	bkv_event_checker events_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	always #1 clk = ~clk;

	// Hard stop for a hung run
	initial begin
		#2_000_000;
		$display("testbench NOT OK");
		$finish;
	end

	// Stall the result side: switch between ready rates after random stretches
	always @(posedge clk) begin
		if (ready_mode_left == 0) begin
			case ($urandom_range(0, 3))
				0: ready_pct = 100;
				1: ready_pct = 70;
				2: ready_pct = 30;
				default: ready_pct = 8;
			endcase
			ready_mode_left = $urandom_range(16, 200);
		end else begin
			ready_mode_left--;
		end
		result_ready <= ($urandom_range(0, 99) < ready_pct);
	end

	task automatic push_byte(input logic [7:0] b);
		item_t it;
		it.data_byte  = b;
		it.final_byte = 1'b0;
		file_bytes = {file_bytes, it};
	endtask

	// Known key in random case, now and then one letter short or one too many
	task automatic push_known_key(input int which);
		int n;
		int variant;
		int i;
		logic [7:0] c;
		variant = $urandom_range(0, 19);
		n = KEY_LEN[which];
		if (variant == 0)
			n = n - 1;
		for (i = 0; i < n; i++) begin
			c = KEY_TEXT[which][i];
			if ($urandom_range(0, 1) == 1)
				c = c - 8'h20;
			push_byte(c);
		end
		if (variant == 1)
			push_byte(8'h61 + 8'($urandom_range(0, 25)));
		push_byte(8'h00);
	endtask

	// Arbitrary key, sometimes empty, sometimes past the saturation length
	task automatic push_random_key();
		int n;
		n = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 5);
		repeat (n) push_byte(8'($urandom_range(1, 255)));
		push_byte(8'h00);
	endtask

	task automatic push_some_key(input int favored);
		int r;
		r = $urandom_range(0, 99);
		if (favored >= 0 && r < 70)
			push_known_key(favored);
		else if (r < 85)
			push_known_key(int'($urandom_range(0, NKEYS - 1)));
		else
			push_random_key();
	endtask

	// One non-map element with its key and value
	task automatic push_element();
		int r;
		int n;
		int s;
		logic [7:0] t;
		r = $urandom_range(0, 99);
		if (r < 38) begin
			push_byte(TYPE_STRING);
			push_some_key(int'($urandom_range(KEY_APPNAME, KEY_ICON)));
			n = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 6);
			repeat (n) push_byte(8'($urandom_range(1, 255)));
			push_byte(8'h00);
		end else if (r < 63) begin
			push_byte(TYPE_INT32);
			push_some_key(KEY_APPID);
			s = $urandom_range(0, 9);
			repeat (4) push_byte(s == 0 ? 8'h00 : s == 1 ? 8'hFF : 8'($urandom_range(0, 255)));
		end else if (r < 80) begin
			case ($urandom_range(0, 2))
				0: t = TYPE_FLOAT;
				1: t = TYPE_PTR;
				default: t = TYPE_COLOR;
			endcase
			push_byte(t);
			push_some_key(-1);
			repeat (4) push_byte(8'($urandom_range(0, 255)));
		end else if (r < 96) begin
			push_byte(($urandom_range(0, 1) == 1) ? TYPE_UINT64 : TYPE_INT64);
			push_some_key(-1);
			repeat (8) push_byte(8'($urandom_range(0, 255)));
		end else begin
			// type byte the parser does not know
			case ($urandom_range(0, 3))
				0: t = 8'h05;
				1: t = 8'h09;
				2: t = 8'h0B + 8'($urandom_range(0, 8'hF4));
				default: t = 8'hFF;
			endcase
			push_byte(t);
			push_some_key(-1);
			repeat (3) push_byte(8'($urandom_range(0, 255)));
		end
	endtask

	// One entry map; a deep one pushes nesting up to or past the limit
	task automatic push_entry();
		int level;
		int target;
		int steps;
		int r;
		bit deep;
		push_byte(TYPE_MAP);
		if ($urandom_range(0, 1) == 1) begin
			push_byte(8'h30 + 8'($urandom_range(0, 9)));
			push_byte(8'h00);
		end else begin
			push_random_key();
		end
		level = 1;
		deep = ($urandom_range(0, 6) == 0);
		target = deep ? $urandom_range(DEF_MAX_DEPTH, DEF_MAX_DEPTH + 1) : 3;
		steps = deep ? 18 : $urandom_range(0, 5);
		repeat (steps) begin
			r = $urandom_range(0, 99);
			if (level < target && r < (deep ? 70 : 15)) begin
				push_byte(TYPE_MAP);
				push_some_key(-1);
				level++;
			end else if (level > 1 && r >= 85) begin
				push_byte(TYPE_END);
				level--;
			end else begin
				push_element();
			end
		end
		while (level > 0) begin
			push_byte(TYPE_END);
			level--;
		end
	endtask

	// Well-formed file, or close to it when the header key comes out wrong or the closing byte is left off
	task automatic build_file();
		int n;
		int r;
		file_bytes.delete();
		push_byte(TYPE_MAP);
		if ($urandom_range(0, 9) == 0)
			push_random_key();
		else
			push_known_key(KEY_SHORTCUTS);
		n = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 2);
		repeat (n) push_entry();
		r = $urandom_range(0, 9);
		if (r < 6) begin
			push_byte(TYPE_END);
		end else if (r == 9) begin
			// junk after the closing byte is ignored up to end of file
			push_byte(TYPE_END);
			repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
		end
	endtask

	// Offer one byte transaction; open a new burst after a random gap
	task automatic send_byte(input item_t it);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 24);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		burst_left--;
		items_sent++;
	endtask

	// Mark the last byte as end of file and stream the whole file
	task automatic send_file();
		file_bytes[file_bytes.size() - 1].final_byte = 1'b1;
		foreach (file_bytes[i])
			send_byte(file_bytes[i]);
		file_bytes.delete();
	endtask

	initial begin
		string hdr_text;
		int mode;
		int cut;
		int idx;
		int waited;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Bad header type at the top of the byte range
		push_byte(8'hFF);
		send_file();
		// File ends inside the header key
		push_byte(TYPE_MAP);
		send_file();
		// Header key that is not the expected one
		push_byte(TYPE_MAP);
		push_byte(8'h61);
		push_byte(8'h00);
		send_file();
		// Empty file, header key in upper case
		hdr_text = "SHORTCUTS";
		push_byte(TYPE_MAP);
		foreach (hdr_text[i])
			push_byte(hdr_text[i]);
		push_byte(8'h00);
		push_byte(TYPE_END);
		send_file();

		// Random files: mostly well formed, some cut short, corrupted or pure noise
		while (items_sent < ITEM_GOAL) begin
			mode = $urandom_range(0, 99);
			build_file();
			if (mode >= 70 && mode < 85) begin
				cut = $urandom_range(0, file_bytes.size() - 1);
				while (file_bytes.size() > cut + 1)
					void'(file_bytes.pop_back());
			end else if (mode >= 85 && mode < 95) begin
				idx = $urandom_range(0, file_bytes.size() - 1);
				file_bytes[idx].data_byte = 8'($urandom_range(0, 255));
			end else if (mode >= 95) begin
				file_bytes.delete();
				repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(0, 255)));
			end
			send_file();
		end
		item_valid <= 1'b0;

		// Drain: wait for every predicted event, then keep watching for strays
		@(posedge clk);
		waited = 0;
		while (outstanding != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		if (outstanding != 0) begin
			$display("testbench NOT OK");
			$finish;
		end else begin
			repeat (8) @(posedge clk);
			if (mismatches == 0 && outstanding == 0)
				$display("testbench OK");
			else
				$display("testbench NOT OK");
			$finish;
		end
	end

endmodule

// ===== filelist.f =====
design/bkv_pkg.sv
design/bkv_parse.sv
design/bkv_outq.sv
design/binary_keyvalue_shortcut_parser.sv
dv/bkv_event_checker.sv
dv/testbench.sv
